@@ design/cnop_pkg.sv @@
// cnop_pkg: shared constants, codes and types of the chaff nop inserter
// no dependencies; imported by cnop_mul, cnop_rng, chaff_nop_inserter_unit and its bench
package cnop_pkg;

	// dispatch geometry
	localparam int MAX_WIDTH  = 16;
	localparam int MAX_GROUPS = 4;
	localparam int UNIT_MAX   = MAX_WIDTH * MAX_GROUPS;
	localparam int EW_W       = $clog2(MAX_WIDTH + 1);
	localparam int EG_W       = $clog2(MAX_GROUPS + 1);
	localparam int UNIT_W     = $clog2(UNIT_MAX + 1);
	localparam int POS_W      = $clog2(UNIT_MAX);
	localparam int RED_W      = $clog2(POS_W + 1);

	// configuration register widths
	localparam int IW_W       = 5;
	localparam int GC_W       = 3;
	localparam int NOP_W      = 8;
	localparam int ROC_W      = 2;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 2;

	// stream widths
	localparam int OP_W        = 2;
	localparam int IN_TDATA_W  = 128;
	localparam int OUT_TDATA_W = 64;

	// splitmix64 constants
	localparam logic [63:0] SM_GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] SM_MIX1   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] SM_MIX2   = 64'h94d049bb133111eb;
	localparam int          SM_SH1    = 30;
	localparam int          SM_SH2    = 27;
	localparam int          SM_SH3    = 31;

	typedef enum logic [OP_W-1:0] {
		OP_BEGIN = 2'd0,
		OP_INSTR = 2'd1,
		OP_PAD   = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ISSUE_WIDTH = 2'd0,
		CFG_GROUP_COUNT = 2'd1,
		CFG_NOP_CODE    = 2'd2,
		CFG_REG_OPERAND = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MUL_IDLE,
		MUL_LL,
		MUL_LH,
		MUL_HL,
		MUL_ACC
	} mul_phase_t;

	typedef enum logic [2:0] {
		RNG_IDLE,
		RNG_MIX1,
		RNG_WAIT1,
		RNG_MIX2,
		RNG_WAIT2
	} rng_phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_DECIDE,
		ST_PASS,
		ST_REQ,
		ST_WAIT,
		ST_EMIT
	} top_state_t;

	typedef struct packed {
		logic load;
		logic start;
	} rng_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rng_sts_t;

endpackage

@@ design/cnop_mul.sv @@
// cnop_mul: low 64 bits of a 64x64 product from one shared 32x32 multiplier
// three partial products (LL, LH, HL) accumulated in turn; uses cnop_pkg
module cnop_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);
	import cnop_pkg::*;

	mul_phase_t  phase_q, phase_d;
	logic [63:0] a_q, b_q;
	logic [31:0] op_x, op_y;
	logic [63:0] prod_s1;
	logic [63:0] acc_q;
	logic        done_q;

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			MUL_IDLE: if (start) phase_d = MUL_LL;
			MUL_LL:   phase_d = MUL_LH;
			MUL_LH:   phase_d = MUL_HL;
			MUL_HL:   phase_d = MUL_ACC;
			MUL_ACC:  phase_d = MUL_IDLE;
			default:  phase_d = MUL_IDLE;
		endcase
	end

	always_comb begin
		case (phase_q)
			MUL_LH: begin
				op_x = a_q[31:0];
				op_y = b_q[63:32];
			end
			MUL_HL: begin
				op_x = a_q[63:32];
				op_y = b_q[31:0];
			end
			default: begin
				op_x = a_q[31:0];
				op_y = b_q[31:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MUL_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == MUL_ACC);
		end
	end

	// cross terms only touch the upper half
	always_ff @(posedge clk) begin
		if (phase_q == MUL_IDLE && start) begin
			a_q <= a;
			b_q <= b;
		end
		prod_s1 <= op_x * op_y;
		case (phase_q)
			MUL_LH:           acc_q <= prod_s1;
			MUL_HL, MUL_ACC:  acc_q[63:32] <= acc_q[63:32] + prod_s1[31:0];
			default:          acc_q <= acc_q;
		endcase
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

@@ design/cnop_rng.sv @@
// cnop_rng: splitmix64 generator state and its mixing sequencer
// drives the shared multiplier in cnop_mul; uses cnop_pkg
module cnop_rng (
	input  logic               clk,
	input  logic               arst_n,
	input  cnop_pkg::rng_ctl_t ctl,
	input  logic [63:0]        seed,
	output cnop_pkg::rng_sts_t sts,
	output logic [63:0]        r
);
	import cnop_pkg::*;

	rng_phase_t  phase_q, phase_d;
	logic [63:0] state_q;
	logic [63:0] z_q;
	logic        done_q;
	logic        mul_start, mul_done;
	logic [63:0] mul_a, mul_b, mul_p;

	cnop_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			RNG_IDLE:  if (ctl.start) phase_d = RNG_MIX1;
			RNG_MIX1:  phase_d = RNG_WAIT1;
			RNG_WAIT1: if (mul_done) phase_d = RNG_MIX2;
			RNG_MIX2:  phase_d = RNG_WAIT2;
			RNG_WAIT2: if (mul_done) phase_d = RNG_IDLE;
			default:   phase_d = RNG_IDLE;
		endcase
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = z_q ^ (z_q >> SM_SH1);
		mul_b     = SM_MIX1;
		case (phase_q)
			RNG_MIX1: mul_start = 1'b1;
			RNG_MIX2: begin
				mul_start = 1'b1;
				mul_a     = z_q ^ (z_q >> SM_SH2);
				mul_b     = SM_MIX2;
			end
			default: mul_start = 1'b0;
		endcase
		sts.busy = (phase_q != RNG_IDLE);
		sts.done = done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= RNG_IDLE;
			state_q <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == RNG_WAIT2) && mul_done;
			if (ctl.load)
				state_q <= seed;
			else if (ctl.start && phase_q == RNG_IDLE)
				state_q <= state_q + SM_GOLDEN;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && phase_q == RNG_IDLE)
			z_q <= state_q + SM_GOLDEN;
		else if (phase_q == RNG_WAIT1 && mul_done)
			z_q <= mul_p;
		else if (phase_q == RNG_WAIT2 && mul_done)
			z_q <= mul_p ^ (mul_p >> SM_SH3);
	end

	assign r = z_q;

endmodule

@@ design/chaff_nop_inserter_unit.sv @@
// chaff_nop_inserter_unit: passes instructions and pads them with chaff nops
// one item at a time; begin, unknown and empty-unit pad transactions finish on accept, others
// reduce the unit position first, then the real instruction leaves (straight from accept on
// an empty unit) ahead of its chaff nops, or a pad emits only chaff nops, each chaff nop
// drawn from splitmix64 by two 64-bit multiplies of three partial products on one 32x32 unit
// s_tready is low until the last result of an item sits in the output register; arst_n clears
// config to its defaults, generator state and position to zero
module chaff_nop_inserter_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cnop_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cnop_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// seed[63:0], opcode, flags, reg_a, reg_b, aux[31:0]
	input  logic [cnop_pkg::IN_TDATA_W-1:0]     s_tdata,
	// operation
	input  logic [cnop_pkg::OP_W-1:0]           s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// out_opcode, out_flags, out_reg_a, out_reg_b, out_aux[31:0]
	output logic [cnop_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// is_chaff
	output logic                                m_tuser,
	output logic                                m_tlast
);
	import cnop_pkg::*;

	// configuration
	logic [IW_W-1:0]  issue_width_q;
	logic [GC_W-1:0]  group_count_q;
	logic [NOP_W-1:0] nop_code_q;
	logic [ROC_W-1:0] reg_code_q;

	// control
	top_state_t       state_q, state_d;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] rem_q;
	logic [RED_W-1:0] k_q;
	op_t              op_q;
	logic             m_tvalid_q;

	// payload
	logic [63:0]              instr_q;
	logic [OUT_TDATA_W-1:0]   m_tdata_q;
	logic                     m_tuser_q;
	logic                     m_tlast_q;

	logic [EW_W-1:0]          eff_w;
	logic [EG_W-1:0]          eff_g;
	logic [UNIT_W-1:0]        unit;
	logic                     unit_zero;
	logic                     accept;
	op_t                      s_op;
	logic                     out_free;
	logic [POS_W+UNIT_W-1:0]  red_div;
	logic                     red_ge;
	logic [EW_W-1:0]          n_items;
	logic [POS_W-1:0]         chaff_cnt;
	logic [UNIT_W:0]          pos_sum;
	logic [UNIT_W-1:0]        need_full;
	logic [POS_W-1:0]         need;
	logic                     load_real, load_chaff;
	rng_ctl_t                 rng_ctl;
	rng_sts_t                 rng_sts;
	logic [63:0]              rnd;

	cnop_rng u_rng (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rng_ctl),
		.seed   (s_tdata[63:0]),
		.sts    (rng_sts),
		.r      (rnd)
	);

	assign eff_w = (int'(issue_width_q) > MAX_WIDTH) ? EW_W'(MAX_WIDTH) : EW_W'(issue_width_q);
	assign eff_g = (int'(group_count_q) > MAX_GROUPS) ? EG_W'(MAX_GROUPS) : EG_W'(group_count_q);
	assign unit      = UNIT_W'(eff_w) * UNIT_W'(eff_g);
	assign unit_zero = (unit == '0);

	assign s_op     = op_t'(s_tuser);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// restoring reduction of the position, one quotient bit per cycle
	assign red_div = {{POS_W{1'b0}}, unit} << k_q;
	assign red_ge  = ({{UNIT_W{1'b0}}, pos_q} >= red_div);

	assign n_items   = (eff_w == '0) ? EW_W'(1) : eff_w;
	assign chaff_cnt = (eff_w > EW_W'(1)) ? POS_W'(eff_w - EW_W'(1)) : '0;
	assign pos_sum   = (UNIT_W+1)'(pos_q) + (UNIT_W+1)'(n_items);
	assign need_full = unit - UNIT_W'(pos_q);
	assign need      = (pos_q == '0) ? '0 : need_full[POS_W-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (s_op)
						OP_INSTR: state_d = unit_zero ? ST_PASS : ST_REDUCE;
						OP_PAD:   state_d = unit_zero ? ST_IDLE : ST_REDUCE;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_REDUCE: if (k_q == '0) state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (op_q == OP_INSTR)
					state_d = ST_PASS;
				else
					state_d = (need == '0) ? ST_IDLE : ST_REQ;
			end
			ST_PASS: if (out_free) state_d = (chaff_cnt == '0) ? ST_IDLE : ST_REQ;
			ST_REQ:  state_d = ST_WAIT;
			ST_WAIT: if (rng_sts.done) state_d = ST_EMIT;
			ST_EMIT: if (out_free) state_d = (rem_q == POS_W'(1)) ? ST_IDLE : ST_REQ;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = (state_q == ST_IDLE);
		rng_ctl.load  = 1'b0;
		rng_ctl.start = 1'b0;
		load_real     = 1'b0;
		load_chaff    = 1'b0;
		case (state_q)
			ST_IDLE: rng_ctl.load = accept &&
				(s_op == OP_BEGIN || (s_op == OP_PAD && !unit_zero));
			ST_PASS: load_real     = out_free;
			ST_REQ:  rng_ctl.start = 1'b1;
			ST_EMIT: load_chaff    = out_free;
			default: rng_ctl.start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_width_q <= IW_W'(1);
			group_count_q <= GC_W'(1);
			nop_code_q    <= '0;
			reg_code_q    <= ROC_W'(1);
			state_q       <= ST_IDLE;
			pos_q         <= '0;
			rem_q         <= '0;
			k_q           <= '0;
			op_q          <= OP_BEGIN;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_ISSUE_WIDTH: issue_width_q <= cfg_data[IW_W-1:0];
					CFG_GROUP_COUNT: group_count_q <= cfg_data[GC_W-1:0];
					CFG_NOP_CODE:    nop_code_q    <= cfg_data[NOP_W-1:0];
					CFG_REG_OPERAND: reg_code_q    <= cfg_data[ROC_W-1:0];
					default:         nop_code_q    <= nop_code_q;
				endcase
			end
			state_q <= state_d;

			if (accept) begin
				op_q <= s_op;
				k_q  <= RED_W'(POS_W - 1);
				if (s_op == OP_BEGIN)
					pos_q <= '0;
			end

			if (state_q == ST_REDUCE) begin
				if (red_ge)
					pos_q <= pos_q - red_div[POS_W-1:0];
				if (k_q != '0)
					k_q <= k_q - RED_W'(1);
			end

			if (state_q == ST_DECIDE && op_q == OP_PAD) begin
				rem_q <= need;
				pos_q <= '0;
			end

			if (load_real) begin
				rem_q <= chaff_cnt;
				if (!unit_zero)
					pos_q <= (pos_sum >= (UNIT_W+1)'(unit)) ?
						POS_W'(pos_sum - (UNIT_W+1)'(unit)) : POS_W'(pos_sum);
			end

			if (load_chaff)
				rem_q <= rem_q - POS_W'(1);

			if (load_real || load_chaff)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// instruction fields held for the pass-through transaction
	always_ff @(posedge clk) begin
		if (accept)
			instr_q <= s_tdata[IN_TDATA_W-1:64];
		if (load_real) begin
			m_tdata_q <= instr_q;
			m_tuser_q <= 1'b0;
			m_tlast_q <= (chaff_cnt == '0);
		end else if (load_chaff) begin
			m_tdata_q <= {rnd[47:16], 4'b0000, rnd[15:12], 4'b0000, rnd[11:8],
				reg_code_q, reg_code_q, rnd[3:0], nop_code_q};
			m_tuser_q <= 1'b1;
			m_tlast_q <= (rem_q == POS_W'(1));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	a_rng_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		rng_sts.done |-> state_q == ST_WAIT)
		else $error("generator finished outside the wait state");

	a_accept_rng_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !rng_sts.busy)
		else $error("transaction accepted while generator busy");

	a_pos_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) |-> ({1'b0, pos_q} < (POS_W+1)'(unit)))
		else $error("position not reduced below the unit");

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REQ || state_q == ST_WAIT || state_q == ST_EMIT) |-> rem_q != '0)
		else $error("chaff generation with nothing left to emit");

endmodule

@@ tb/sv/tb_chaff_nop_inserter_unit.sv @@
// tb_chaff_nop_inserter_unit: self-checking bench for the chaff nop inserter
// predicts the pass-through and splitmix64 chaff stream per transaction, checks it in order
// depends on cnop_pkg and chaff_nop_inserter_unit only
module tb_chaff_nop_inserter_unit;
	import cnop_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 60;

	typedef struct {
		logic [OP_W-1:0] op;
		logic [63:0]     seed;
		logic [7:0]      opcode;
		logic [7:0]      flags;
		logic [7:0]      reg_a;
		logic [7:0]      reg_b;
		logic [31:0]     aux;
	} instr_item_t;

	typedef struct {
		logic [7:0]  opcode;
		logic [7:0]  flags;
		logic [7:0]  reg_a;
		logic [7:0]  reg_b;
		logic [31:0] aux;
		logic        chaff;
		logic        is_last;
	} emitted_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// seed[63:0], opcode, flags, reg_a, reg_b, aux[31:0]
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	// operation
	logic [OP_W-1:0]        s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// out_opcode, out_flags, out_reg_a, out_reg_b, out_aux[31:0]
	logic [OUT_TDATA_W-1:0] m_tdata;
	// is_chaff
	logic                   m_tuser;
	logic                   m_tlast;

	// predictor copy of the block state and registers
	logic [63:0]    gen_state = '0;
	int unsigned    unit_pos = 0;
	logic [IW_W-1:0]  cur_width = 5'd1;
	logic [GC_W-1:0]  cur_groups = 3'd1;
	logic [NOP_W-1:0] cur_nop = 8'd0;
	logic [ROC_W-1:0] cur_regcode = 2'd1;

	instr_item_t queued_instrs[$];
	emitted_t    predicted_emits[$];
	int          mismatch_count = 0;
	int          emits_seen = 0;
	int          cycle_count = 0;
	bit          no_idle = 1'b0;

	chaff_nop_inserter_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic queue_item(input instr_item_t it);
		queued_instrs.insert(queued_instrs.size(), it);
	endtask

	task automatic expect_emit(input emitted_t e);
		predicted_emits.insert(predicted_emits.size(), e);
	endtask

	function automatic logic [63:0] splitmix_next();
		logic [63:0] z;
		gen_state = gen_state + SM_GOLDEN;
		z = gen_state;
		z = (z ^ (z >> SM_SH1)) * SM_MIX1;
		z = (z ^ (z >> SM_SH2)) * SM_MIX2;
		return z ^ (z >> SM_SH3);
	endfunction

	task automatic push_chaff(input bit fin);
		logic [63:0] r;
		emitted_t e;
		r = splitmix_next();
		e.opcode  = cur_nop;
		e.flags   = {cur_regcode, cur_regcode, r[3:0]};
		e.reg_a   = {4'd0, r[11:8]};
		e.reg_b   = {4'd0, r[15:12]};
		e.aux     = r[47:16];
		e.chaff   = 1'b1;
		e.is_last = fin;
		expect_emit(e);
	endtask

	task automatic predict_emission(input instr_item_t it);
		int unsigned w, u, n, k;
		emitted_t e;
		w = (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
		u = w * ((cur_groups > MAX_GROUPS) ? MAX_GROUPS : cur_groups);
		case (it.op)
			OP_BEGIN: begin
				gen_state = it.seed;
				unit_pos = 0;
			end
			OP_INSTR: begin
				n = (w > 1) ? w : 1;
				e = '{opcode: it.opcode, flags: it.flags, reg_a: it.reg_a, reg_b: it.reg_b,
					aux: it.aux, chaff: 1'b0, is_last: (n == 1)};
				expect_emit(e);
				for (k = 1; k < n; k++)
					push_chaff(k == n - 1);
				// an empty unit leaves the position alone
				if (u != 0)
					unit_pos = (unit_pos % u + n) % u;
			end
			OP_PAD: begin
				if (u != 0) begin
					gen_state = it.seed;
					n = (u - unit_pos % u) % u;
					for (k = 0; k < n; k++)
						push_chaff(k == n - 1);
					unit_pos = 0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// sender: holds each transaction until taken, idles in short bursts
	always @(posedge clk or negedge arst_n) begin : sender
		instr_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (queued_instrs.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(0, 6)) @(posedge clk);
			end else begin
				nxt = queued_instrs.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {nxt.aux, nxt.reg_b, nxt.reg_a, nxt.flags, nxt.opcode, nxt.seed};
				s_tuser  <= nxt.op;
			end
		end
	end

	// receiver: random stall bursts plus one long hold-off while the sender is busy
	always @(posedge clk or negedge arst_n) begin : receiver
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (emits_seen >= 100 && queued_instrs.size() > 5 && !no_idle) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				// only once: wait until the run is quiet for good
				while (!no_idle) begin
					if ($urandom_range(0, 5) == 0) begin
						m_tready <= 1'b0;
						repeat ($urandom_range(1, 7)) @(posedge clk);
					end
					m_tready <= 1'b1;
					@(posedge clk);
				end
				m_tready <= 1'b1;
				forever @(posedge clk);
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 6)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// input side feeds the predictor, output side is checked against it
	always @(posedge clk) begin : scoreboard
		instr_item_t it;
		emitted_t e;
		if (arst_n && s_tvalid && s_tready) begin
			it.op     = s_tuser;
			it.seed   = s_tdata[63:0];
			it.opcode = s_tdata[71:64];
			it.flags  = s_tdata[79:72];
			it.reg_a  = s_tdata[87:80];
			it.reg_b  = s_tdata[95:88];
			it.aux    = s_tdata[127:96];
			predict_emission(it);
		end
		if (arst_n && m_tvalid && m_tready) begin
			emits_seen <= emits_seen + 1;
			if (predicted_emits.size() == 0) begin
				report_mismatch("unexpected transaction", m_tdata, '0);
			end else begin
				e = predicted_emits.pop_front();
				if (m_tdata[7:0] !== e.opcode)
					report_mismatch("out_opcode", 64'(m_tdata[7:0]), 64'(e.opcode));
				if (m_tdata[15:8] !== e.flags)
					report_mismatch("out_flags", 64'(m_tdata[15:8]), 64'(e.flags));
				if (m_tdata[23:16] !== e.reg_a)
					report_mismatch("out_reg_a", 64'(m_tdata[23:16]), 64'(e.reg_a));
				if (m_tdata[31:24] !== e.reg_b)
					report_mismatch("out_reg_b", 64'(m_tdata[31:24]), 64'(e.reg_b));
				if (m_tdata[63:32] !== e.aux)
					report_mismatch("out_aux", 64'(m_tdata[63:32]), 64'(e.aux));
				if (m_tuser !== e.chaff)
					report_mismatch("is_chaff", 64'(m_tuser), 64'(e.chaff));
				if (m_tlast !== e.is_last)
					report_mismatch("last", 64'(m_tlast), 64'(e.is_last));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic instr_item_t make_item(input logic [OP_W-1:0] op,
		input logic [63:0] seed, input logic [7:0] opcode, input logic [7:0] flags,
		input logic [7:0] reg_a, input logic [7:0] reg_b, input logic [31:0] aux);
		instr_item_t it;
		it.op = op;
		it.seed = seed;
		it.opcode = opcode;
		it.flags = flags;
		it.reg_a = reg_a;
		it.reg_b = reg_b;
		it.aux = aux;
		return it;
	endfunction

	function automatic instr_item_t rand_item(input logic [OP_W-1:0] op);
		logic [63:0] seed;
		case ($urandom_range(0, 15))
			0:       seed = '0;
			1:       seed = '1;
			default: seed = {$urandom, $urandom};
		endcase
		return make_item(op, seed, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			$urandom);
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_ISSUE_WIDTH: cur_width   = val[IW_W-1:0];
			CFG_GROUP_COUNT: cur_groups  = val[GC_W-1:0];
			CFG_NOP_CODE:    cur_nop     = val[NOP_W-1:0];
			CFG_REG_OPERAND: cur_regcode = val[ROC_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int iw, input int gc, input int nop, input int roc);
		write_reg(CFG_ISSUE_WIDTH, CFG_DATA_W'(iw));
		write_reg(CFG_GROUP_COUNT, CFG_DATA_W'(gc));
		write_reg(CFG_NOP_CODE, CFG_DATA_W'(nop));
		write_reg(CFG_REG_OPERAND, CFG_DATA_W'(roc));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for every transaction to drain, then let the block go quiet
	task automatic drain();
		while (queued_instrs.size() != 0 || s_tvalid || predicted_emits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly begin / instructions / pad blocks, with broken blocks and stray items
	task automatic add_random(input int budget);
		int added, k, n;
		bit skip_begin, skip_pad;
		added = 0;
		while (added < budget) begin
			if ($urandom_range(0, 9) < 7) begin
				skip_begin = ($urandom_range(0, 5) == 0);
				skip_pad = ($urandom_range(0, 5) == 0);
				n = $urandom_range(1, 6);
				if (!skip_begin) begin
					queue_item(rand_item(OP_BEGIN));
					added++;
				end
				for (k = 0; k < n; k++)
					queue_item(rand_item(OP_INSTR));
				added += n;
				if (!skip_pad) begin
					queue_item(rand_item(OP_PAD));
					added++;
				end
			end else begin
				queue_item(rand_item(OP_W'($urandom_range(0, 3))));
				added++;
			end
		end
	endtask

	initial begin : stimulus
		int p;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: unknown operation, field extremes, silent begin and pad
		queue_item(make_item(OP_UNUSED, '1, '1, '1, '1, '1, '1));
		queue_item(make_item(OP_INSTR, '0, '0, '0, '0, '0, '0));
		queue_item(make_item(OP_INSTR, '1, '1, '1, '1, '1, '1));
		queue_item(make_item(OP_BEGIN, '0, '0, '0, '0, '0, '0));
		queue_item(make_item(OP_PAD, '1, '0, '0, '0, '0, '0));
		add_random(30);
		drain();

		// leave the position at one in a small unit
		set_config(1, 4, 8'hff, 3);
		queue_item(make_item(OP_BEGIN, '1, '0, '0, '0, '0, '0));
		queue_item(make_item(OP_INSTR, {$urandom, $urandom}, 8'h5a, 8'h0f,
			8'hf0, 8'h3c, 32'h8000_0001));
		drain();

		// widest unit: the pad now owes 63 chaff nops
		set_config(16, 4, 8'ha5, 0);
		queue_item(make_item(OP_PAD, {$urandom, $urandom}, '0, '0, '0, '0, '0));
		queue_item(rand_item(OP_INSTR));
		queue_item(rand_item(OP_INSTR));
		add_random(30);
		drain();

		// stale position: shrink the unit below the position left over
		set_config(2, 1, 8'h00, 2);
		queue_item(rand_item(OP_INSTR));
		queue_item(rand_item(OP_PAD));
		add_random(30);
		drain();

		// empty unit through zero width
		set_config(0, 3, 8'h81, 1);
		queue_item(rand_item(OP_INSTR));
		queue_item(rand_item(OP_PAD));
		add_random(20);
		drain();

		// settings above the maxima are clamped
		set_config(31, 7, 8'h3c, 1);
		queue_item(rand_item(OP_INSTR));
		queue_item(rand_item(OP_PAD));
		add_random(30);
		drain();

		// empty unit through zero groups
		set_config(5, 0, 8'h7e, 3);
		queue_item(rand_item(OP_INSTR));
		queue_item(rand_item(OP_PAD));
		add_random(20);
		drain();

		for (p = 0; p < 4; p++) begin
			set_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6),
				$urandom_range(0, 7), $urandom_range(0, 255), $urandom_range(0, 3));
			// final stretch runs without idling on either side
			if (p == 3)
				no_idle = 1'b1;
			add_random(35);
			drain();
		end

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
